FILE: hdl/sctpcrc_pkg.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker package
// Shared constants, verdict codes, the input item type and the byte-wise
// CRC32C update.
// ----------------------------------------------------------------------------
package sctpcrc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam int          POS_W      = 4;
    localparam logic [3:0]  HEADER_LEN = 4'd12;

    localparam logic [3:0]  POS_SRC_HI = 4'd0;
    localparam logic [3:0]  POS_SRC_LO = 4'd1;
    localparam logic [3:0]  POS_DST_HI = 4'd2;
    localparam logic [3:0]  POS_DST_LO = 4'd3;
    localparam logic [3:0]  POS_CSUM   = 4'd8;

    localparam logic [1:0]  VERDICT_OK       = 2'd0;
    localparam logic [1:0]  VERDICT_SHORT    = 2'd1;
    localparam logic [1:0]  VERDICT_ZERO_PRT = 2'd2;
    localparam logic [1:0]  VERDICT_MISMATCH = 2'd3;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    // Reflected CRC32C update by one byte; the loop unrolls into an XOR network.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/sctpcrc_in_if.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker input channel
// Valid/ready channel that carries one packet byte per item.
// ----------------------------------------------------------------------------
interface sctpcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

FILE: hdl/sctpcrc_out_if.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker result channel
// Valid/ready channel that carries one packet verdict per item.
// ----------------------------------------------------------------------------
interface sctpcrc_out_if;
    logic        valid;
    logic        ready;
    logic        packet_ok;
    logic [1:0]  verdict;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;

    modport source (output valid, output packet_ok, output verdict,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input packet_ok, input verdict,
                    input computed_crc, input received_crc, output ready);
endinterface

FILE: hdl/sctpcrc_in_reg.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker input register
// Holds one accepted byte until the engine consumes it.
// ----------------------------------------------------------------------------
module sctpcrc_in_reg
    import sctpcrc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    sctpcrc_in_if.sink     i_in,
    input  logic           i_take,
    output logic           o_valid,
    output t_in_item       o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.packet_byte <= i_in.packet_byte;
            r_item.last_byte   <= i_in.last_byte;
        end
    end

endmodule

FILE: hdl/sctpcrc_engine.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker engine
// Per-packet CRC and header capture, verdict logic and the result register.
// ----------------------------------------------------------------------------
module sctpcrc_engine
    import sctpcrc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_big_endian,
    input  logic           i_item_valid,
    input  t_in_item       i_item,
    output logic           o_take,
    sctpcrc_out_if.source  o_out
);

    logic [31:0]      r_crc;
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_src;
    logic [15:0]      r_dst;
    logic [31:0]      r_stored;

    logic [31:0]      n_crc;
    logic [POS_W-1:0] n_pos;
    logic [15:0]      n_src;
    logic [15:0]      n_dst;
    logic [31:0]      n_stored;
    logic [7:0]       feed;
    logic [31:0]      computed;
    logic [1:0]       verdict;

    logic             r_out_valid;
    logic             r_ok;
    logic [1:0]       r_verdict;
    logic [31:0]      r_computed;
    logic [31:0]      r_received;

    // A byte that ends no packet makes no result, so it never waits on the output.
    assign o_take = i_item_valid && (!i_item.last_byte || !r_out_valid || o_out.ready);

    always_comb begin
        n_src    = r_src;
        n_dst    = r_dst;
        n_stored = r_stored;
        feed     = i_item.packet_byte;
        if (r_pos == POS_SRC_HI) begin
            n_src[15:8] = i_item.packet_byte;
        end else if (r_pos == POS_SRC_LO) begin
            n_src[7:0] = i_item.packet_byte;
        end else if (r_pos == POS_DST_HI) begin
            n_dst[15:8] = i_item.packet_byte;
        end else if (r_pos == POS_DST_LO) begin
            n_dst[7:0] = i_item.packet_byte;
        end else if (r_pos >= POS_CSUM && r_pos < HEADER_LEN) begin
            // The checksum field enters the CRC as zero.
            feed = 8'd0;
            if (i_big_endian) begin
                n_stored = {r_stored[23:0], i_item.packet_byte};
            end else begin
                n_stored[{r_pos[1:0], 3'b000} +: 8] = i_item.packet_byte;
            end
        end
        n_crc    = crc_byte(r_crc, feed);
        n_pos    = (r_pos < HEADER_LEN) ? r_pos + 1'b1 : r_pos;
        computed = ~n_crc;
        if (n_pos < HEADER_LEN) begin
            verdict = VERDICT_SHORT;
        end else if (n_src == 16'd0 || n_dst == 16'd0) begin
            verdict = VERDICT_ZERO_PRT;
        end else if (computed != n_stored) begin
            verdict = VERDICT_MISMATCH;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_pos    <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_stored <= '0;
        end else if (o_take) begin
            if (i_item.last_byte) begin
                r_crc    <= CRC_INIT;
                r_pos    <= '0;
                r_src    <= '0;
                r_dst    <= '0;
                r_stored <= '0;
            end else begin
                r_crc    <= n_crc;
                r_pos    <= n_pos;
                r_src    <= n_src;
                r_dst    <= n_dst;
                r_stored <= n_stored;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last_byte) begin
            r_ok       <= (verdict == VERDICT_OK);
            r_verdict  <= verdict;
            r_computed <= computed;
            r_received <= n_stored;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.packet_ok    = r_ok;
    assign o_out.verdict      = r_verdict;
    assign o_out.computed_crc = r_computed;
    assign o_out.received_crc = r_received;

endmodule

FILE: hdl/sctp_packet_crc32c_checker_core.sv
// ----------------------------------------------------------------------------
// SCTP packet CRC32C checker
// Top level: configuration register, input register and checking engine.
// ----------------------------------------------------------------------------
// The block takes one packet byte per item and can accept a byte in every
// clock cycle unless a last byte finds the result register full. Each byte
// passes an input register and then the CRC and header logic; a packet's
// verdict is registered when its last byte leaves the input register and
// waits in the result register until taken, while bytes of the next packet
// keep flowing. The byte order of the stored checksum is set by the one-bit
// configuration register; the user must write it only while no packet is in
// flight, and the block itself does not enforce this.
module sctp_packet_crc32c_checker_core
    import sctpcrc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    sctpcrc_in_if.sink     i_in,
    sctpcrc_out_if.source  o_out
);

    logic     r_big_endian;
    logic     item_valid;
    logic     take;
    t_in_item item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            r_big_endian <= i_cfg_wdata;
        end
    end

    sctpcrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    sctpcrc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .o_out        (o_out)
    );

endmodule

FILE: hdl/sctpcrc_checker.sv
// ----------------------------------------------------------------------------
// SCTP CRC32C checker port assertions
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module sctpcrc_checker
    import sctpcrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_packet_ok,
    input logic [1:0]  i_verdict,
    input logic [31:0] i_computed_crc,
    input logic [31:0] i_received_crc
);

    // The result register is empty in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !i_out_valid)
        else $error("result valid right after reset");

    // With no result pending, nothing can hold back the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_ok_matches_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_packet_ok == (i_verdict == VERDICT_OK)))
        else $error("packet_ok disagrees with verdict");

    // A passing packet must carry a checksum equal to the computed one.
    a_ok_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_packet_ok) |-> (i_computed_crc == i_received_crc))
        else $error("packet passed with mismatching checksum");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_verdict)
            && $stable(i_computed_crc) && $stable(i_received_crc)))
        else $error("stalled result changed");

endmodule

bind sctp_packet_crc32c_checker_core sctpcrc_checker u_sctpcrc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_packet_ok    (o_out.packet_ok),
    .i_verdict      (o_out.verdict),
    .i_computed_crc (o_out.computed_crc),
    .i_received_crc (o_out.received_crc)
);
